[rtl/pdcq_pkg.sv]
// ----------------------------------------------------------------------------
// pdcq_pkg
// Shared types and codes for the press duration classifier queue: the event
// codes and the operation word that passes from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package pdcq_pkg;

	localparam int EVENT_W   = 3;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int OPQ_DEPTH = 2;

	// event codes as seen on the result port
	localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
	localparam logic [EVENT_W-1:0] EV_A_SHORT = 3'd1;
	localparam logic [EVENT_W-1:0] EV_A_LONG  = 3'd2;
	localparam logic [EVENT_W-1:0] EV_B_SHORT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_B_LONG  = 3'd4;

	// item kinds
	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// configuration register indexes
	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	// operation word handed from the front to the back
	typedef struct packed {
		logic                is_read;
		logic [EVENT_W-1:0]  code;
	} pdcq_op_t;

endpackage

`default_nettype wire

[rtl/press_duration_classifier_queue.sv]
// ----------------------------------------------------------------------------
// press_duration_classifier_queue
// Two-button press classifier with an event ring.
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel while it is not stalled. Edge
// words update the press state of their button and, when a press ends with a
// duration at or above the debounce threshold, queue a short or long event
// (long at or above the long-press threshold); they give no result. Read
// words give exactly one result: the oldest queued event, or none when the
// ring is empty. The ring keeps at most RING_SLOTS - 1 events and drops new
// ones when full. A read result passes through the front stage register, an
// op queue slot, then the registered ring read that also sets the result
// flag. Throughput is one word per clock when no stall holds the flow. A
// stalled result channel holds the next read word at the back; once the op
// queue fills, the input stalls for every word, edge words included.
// Configuration writes take effect on the next clock and belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module press_duration_classifier_queue
	import pdcq_pkg::*;
#(
	parameter int RING_SLOTS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic              button,
	input  wire logic              edge_fall,
	input  wire logic              edge_rise,
	input  wire logic [TIME_W-1:0] now_ms,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [EVENT_W-1:0]     event_code,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	logic             fr_valid;
	logic             fr_ready;
	pdcq_op_t         fr_op;
	logic             bk_valid;
	logic             bk_ready;
	pdcq_op_t         bk_op;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= 16'd50;
			long_press_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	pdcq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.button     (button),
		.edge_fall  (edge_fall),
		.edge_rise  (edge_rise),
		.now_ms     (now_ms),
		.bounce_min (debounce_q),
		.long_min   (long_press_q),
		.op_valid   (fr_valid),
		.op_ready   (fr_ready),
		.op         (fr_op)
	);

	pdcq_fifo #(
		.DEPTH (OPQ_DEPTH)
	) u_opq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_op    (fr_op),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_op    (bk_op)
	);

	pdcq_back #(
		.RING_SLOTS (RING_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (bk_valid),
		.op_ready   (bk_ready),
		.op         (bk_op),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_code (event_code)
	);

endmodule

`default_nettype wire

[rtl/pdcq_ram.sv]
// ----------------------------------------------------------------------------
// pdcq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcq_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/pdcq_front.sv]
// ----------------------------------------------------------------------------
// pdcq_front
// Accepts input words, tracks the held state and press start of both buttons,
// measures press durations and classifies them into operations for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcq_front
	import pdcq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              kind,
	input  wire logic              button,
	input  wire logic              edge_fall,
	input  wire logic              edge_rise,
	input  wire logic [TIME_W-1:0] now_ms,
	input  wire logic [CFG_W-1:0]  bounce_min,
	input  wire logic [CFG_W-1:0]  long_min,
	output logic                   op_valid,
	input  wire logic              op_ready,
	output pdcq_op_t               op
);

	logic [1:0]              held_q;
	logic [1:0][TIME_W-1:0]  start_q;

	logic                    valid_s1;
	logic                    kind_s1;
	logic                    btn_s1;
	logic                    hit_s1;
	logic [TIME_W-1:0]       dur_s1;

	logic                    fall_new;
	logic                    eff_held;
	logic [TIME_W-1:0]       eff_start;
	logic                    hit;
	logic [TIME_W-1:0]       dur;
	logic                    accept;
	logic                    advance;
	logic                    keep;
	logic                    is_long;
	logic [EVENT_W-1:0]      press_code;

	// fall handled first, then rise against the updated held state
	always_comb begin
		fall_new  = edge_fall && !held_q[button];
		eff_held  = held_q[button] || edge_fall;
		eff_start = fall_new ? now_ms : start_q[button];
		hit       = edge_rise && eff_held;
		dur       = now_ms - eff_start;
	end

	assign advance  = !valid_s1 || !op_valid || op_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	// per-button press tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			start_q <= '0;
		end else if (accept && kind == KIND_EDGE) begin
			held_q[button]  <= eff_held && !edge_rise;
			start_q[button] <= eff_start;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			btn_s1  <= button;
			hit_s1  <= hit;
			dur_s1  <= dur;
		end
	end

	// classify the measured press
	always_comb begin
		keep    = hit_s1 && (dur_s1 >= {{(TIME_W-CFG_W){1'b0}}, bounce_min});
		is_long = dur_s1 >= {{(TIME_W-CFG_W){1'b0}}, long_min};
		if (btn_s1) begin
			press_code = is_long ? EV_B_LONG : EV_B_SHORT;
		end else begin
			press_code = is_long ? EV_A_LONG : EV_A_SHORT;
		end
	end

	// reads always go on, edges only when they make an event
	assign op_valid   = valid_s1 && (kind_s1 == KIND_READ || keep);
	assign op.is_read = kind_s1 == KIND_READ;
	assign op.code    = (kind_s1 == KIND_READ) ? EV_NONE : press_code;

endmodule

`default_nettype wire

[rtl/pdcq_fifo.sv]
// ----------------------------------------------------------------------------
// pdcq_fifo
// Short register queue of operation words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcq_fifo
	import pdcq_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_valid,
	output logic          wr_ready,
	input  wire pdcq_op_t wr_op,
	output logic          rd_valid,
	input  wire logic     rd_ready,
	output pdcq_op_t      rd_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pdcq_op_t          slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_op    = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pdcq_back.sv]
// ----------------------------------------------------------------------------
// pdcq_back
// Carries out operations: pushes classified events into the event ring and
// pops one event per read word into the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcq_back
	import pdcq_pkg::*;
#(
	parameter int RING_SLOTS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               op_valid,
	output logic                    op_ready,
	input  wire pdcq_op_t           op,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [EVENT_W-1:0]      event_code
);

	localparam int AW = $clog2(RING_SLOTS);

	logic [AW-1:0]       wr_pos_q;
	logic [AW-1:0]       rd_pos_q;
	logic [AW-1:0]       wr_next;
	logic [AW-1:0]       rd_next;
	logic                out_valid_q;
	logic                empty_q;
	logic                ring_full;
	logic                ring_empty;
	logic                pop;
	logic                ring_we;
	logic                ring_re;
	logic [EVENT_W-1:0]  ring_rdata;

	always_comb begin
		wr_next    = (wr_pos_q == AW'(RING_SLOTS - 1)) ? '0 : wr_pos_q + 1'b1;
		rd_next    = (rd_pos_q == AW'(RING_SLOTS - 1)) ? '0 : rd_pos_q + 1'b1;
		ring_full  = wr_next == rd_pos_q;
		ring_empty = wr_pos_q == rd_pos_q;
	end

	// reads wait for the result stage, pushes never wait
	assign op_ready = !op.is_read || !out_valid_q || out_ready;
	assign pop      = op_valid && op_ready;
	assign ring_we  = pop && !op.is_read && !ring_full;
	assign ring_re  = pop && op.is_read;

	pdcq_ram #(
		.WIDTH (EVENT_W),
		.DEPTH (RING_SLOTS)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wr_pos_q),
		.wdata (op.code),
		.re    (ring_re),
		.raddr (rd_pos_q),
		.rdata (ring_rdata)
	);

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q <= '0;
			rd_pos_q <= '0;
		end else begin
			if (ring_we) begin
				wr_pos_q <= wr_next;
			end
			if (ring_re && !ring_empty) begin
				rd_pos_q <= rd_next;
			end
		end
	end

	// result stage; ram read data is its payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			empty_q     <= 1'b1;
		end else if (ring_re) begin
			out_valid_q <= 1'b1;
			empty_q     <= ring_empty;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_code = empty_q ? EV_NONE : ring_rdata;

endmodule

`default_nettype wire
